### design/window_nearest_level_distance_macros.svh
// Assertion macros shared by the block's modules.
// Each use names a label, a property and a message; clk and rst come from the using module.
`ifndef WINDOW_NEAREST_LEVEL_DISTANCE_MACROS_SVH
`define WINDOW_NEAREST_LEVEL_DISTANCE_MACROS_SVH

`ifndef ASSERT_OFF

// Check at every edge outside reset.
`define WNLD_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Check at every edge, reset included.
`define WNLD_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`else

`define WNLD_ASSERT(lbl, prop, msg)
`define WNLD_ASSERT_ALWAYS(lbl, prop, msg)

`endif

`endif

### design/wnld_pkg.sv
package wnld_pkg;

  localparam int SIDE_VERTS_DEF = 128;

  localparam int CFG_INDEX_W = 3;
  localparam int CFG_DATA_W  = 16;

  localparam logic [6:0]  GRID_WIDTH_RST  = 7'd1;
  localparam logic [6:0]  GRID_HEIGHT_RST = 7'd1;
  localparam logic [15:0] MIN_LEVEL_RST   = 16'sh0000;
  localparam logic [15:0] MAX_LEVEL_RST   = 16'sh7fff;
  localparam logic [6:0]  MAX_DIST_RST    = 7'd8;

  localparam logic CMD_WRITE = 1'b0;
  localparam logic CMD_QUERY = 1'b1;

  typedef enum logic [CFG_INDEX_W-1:0] {
    REG_GRID_WIDTH  = 3'd0,
    REG_GRID_HEIGHT = 3'd1,
    REG_MIN_LEVEL   = 3'd2,
    REG_MAX_LEVEL   = 3'd3,
    REG_MAX_DIST    = 3'd4
  } cfg_reg_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CHECK,
    ST_SCAN,
    ST_DRAIN,
    ST_ROOT_LOAD,
    ST_ROOT,
    ST_RESULT
  } state_t;

  typedef struct packed {
    logic               cmd;
    logic [6:0]         vert_x;
    logic [6:0]         vert_y;
    logic signed [15:0] level;
  } in_word_t;

  typedef struct packed {
    logic [14:0] distance_q8;
    logic        found;
  } out_word_t;

  typedef struct packed {
    logic start;
    logic wr_en;
    logic scan_issue;
    logic root_load;
    logic root_step;
    logic result_load;
  } ctrl_cmd_t;

  typedef struct packed {
    logic empty;
    logic scan_last;
    logic root_done;
    logic out_free;
  } dp_sts_t;

endpackage

### design/wnld_datapath.sv
`include "window_nearest_level_distance_macros.svh"

module wnld_datapath #(
  parameter int SIDE_VERTS = wnld_pkg::SIDE_VERTS_DEF
) (
  input  logic                             clk,
  input  logic                             rst,
  input  wnld_pkg::in_word_t               in_word,
  input  logic                             cfg_valid,
  input  logic [wnld_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [wnld_pkg::CFG_DATA_W-1:0]  cfg_data,
  input  logic                             out_ready,
  output logic                             out_valid,
  output wnld_pkg::out_word_t              out_word,
  input  wnld_pkg::ctrl_cmd_t              cmd,
  output wnld_pkg::dp_sts_t                sts
);

  localparam int COL_W     = $clog2(SIDE_VERTS);
  localparam int ADDR_W    = 2 * COL_W;
  localparam int MEM_DEPTH = 1 << ADDR_W;
  localparam logic [7:0]  SIDE_MAX = 8'(SIDE_VERTS - 1);
  localparam logic [8:0]  SIDE_LIM = 9'(SIDE_VERTS);
  localparam logic [14:0] BEST_MAX = 15'd32258;
  localparam logic [30:0] ROOT_BIT_TOP = 31'h4000_0000;

  logic [6:0]         grid_width;
  logic [6:0]         grid_height;
  logic signed [15:0] min_level;
  logic signed [15:0] max_level;
  logic [6:0]         max_dist;

  logic [15:0]        mem [MEM_DEPTH];
  logic signed [15:0] rd_data;
  logic [ADDR_W-1:0]  rd_addr;
  logic [ADDR_W-1:0]  wr_addr;
  logic               wr_ok;

  logic [7:0] vx8, vy8, md8;
  logic [7:0] lo_x, lo_y, hi_x_raw, hi_y_raw, lim_x, lim_y, hi_x, hi_y;

  logic [7:0]  qx, qy;
  logic [7:0]  x_lo, x_hi, y_hi;
  logic [7:0]  cx, cy;
  logic        empty;
  logic [7:0]  adx8, ady8;
  logic [13:0] sq_x, sq_y;
  logic [14:0] dsq_next;
  logic [14:0] dsq_a;
  logic        valid_a;
  logic        match;
  logic        hit;
  logic [14:0] best;

  logic [30:0] rt_n, rt_root, rt_bit;
  logic [31:0] rt_sum;
  logic [14:0] cap;

  always_ff @(posedge clk) begin
    if (rst) begin
      grid_width  <= wnld_pkg::GRID_WIDTH_RST;
      grid_height <= wnld_pkg::GRID_HEIGHT_RST;
      min_level   <= wnld_pkg::MIN_LEVEL_RST;
      max_level   <= wnld_pkg::MAX_LEVEL_RST;
      max_dist    <= wnld_pkg::MAX_DIST_RST;
    end else if (cfg_valid) begin
      unique case (wnld_pkg::cfg_reg_t'(cfg_index))
        wnld_pkg::REG_GRID_WIDTH:  grid_width  <= cfg_data[6:0];
        wnld_pkg::REG_GRID_HEIGHT: grid_height <= cfg_data[6:0];
        wnld_pkg::REG_MIN_LEVEL:   min_level   <= cfg_data;
        wnld_pkg::REG_MAX_LEVEL:   max_level   <= cfg_data;
        wnld_pkg::REG_MAX_DIST:    max_dist    <= cfg_data[6:0];
        default: ;
      endcase
    end
  end

  assign vx8 = {1'b0, in_word.vert_x};
  assign vy8 = {1'b0, in_word.vert_y};
  assign md8 = {1'b0, max_dist};

  assign lo_x     = (vx8 > md8) ? vx8 - md8 : 8'd0;
  assign lo_y     = (vy8 > md8) ? vy8 - md8 : 8'd0;
  assign hi_x_raw = vx8 + md8;
  assign hi_y_raw = vy8 + md8;
  assign lim_x    = ({1'b0, grid_width} < SIDE_MAX) ? {1'b0, grid_width} : SIDE_MAX;
  assign lim_y    = ({1'b0, grid_height} < SIDE_MAX) ? {1'b0, grid_height} : SIDE_MAX;
  assign hi_x     = (hi_x_raw < lim_x) ? hi_x_raw : lim_x;
  assign hi_y     = (hi_y_raw < lim_y) ? hi_y_raw : lim_y;

  assign wr_ok   = ({1'b0, vx8} < SIDE_LIM) && ({1'b0, vy8} < SIDE_LIM);
  assign wr_addr = {vy8[COL_W-1:0], vx8[COL_W-1:0]};
  assign rd_addr = {cy[COL_W-1:0], cx[COL_W-1:0]};

  always_ff @(posedge clk) begin
    if (cmd.wr_en && wr_ok) begin
      mem[wr_addr] <= in_word.level;
    end
    rd_data <= mem[rd_addr];
  end

  assign adx8     = (cx >= qx) ? cx - qx : qx - cx;
  assign ady8     = (cy >= qy) ? cy - qy : qy - cy;
  assign sq_x     = {7'd0, adx8[6:0]} * {7'd0, adx8[6:0]};
  assign sq_y     = {7'd0, ady8[6:0]} * {7'd0, ady8[6:0]};
  assign dsq_next = {1'b0, sq_x} + {1'b0, sq_y};

  always_ff @(posedge clk) begin
    if (cmd.start) begin
      qx    <= vx8;
      qy    <= vy8;
      x_lo  <= lo_x;
      x_hi  <= hi_x;
      y_hi  <= hi_y;
      cx    <= lo_x;
      cy    <= lo_y;
      empty <= (lo_x > hi_x) || (lo_y > hi_y);
    end else if (cmd.scan_issue) begin
      if (cx == x_hi) begin
        cx <= x_lo;
        cy <= cy + 8'd1;
      end else begin
        cx <= cx + 8'd1;
      end
    end
    dsq_a <= dsq_next;
  end

  assign match = (rd_data >= min_level) && (rd_data <= max_level);

  always_ff @(posedge clk) begin
    if (rst) begin
      valid_a <= 1'b0;
      hit     <= 1'b0;
    end else begin
      valid_a <= cmd.scan_issue;
      if (cmd.start) begin
        hit <= 1'b0;
      end else if (valid_a && match && (!hit || dsq_a < best)) begin
        hit <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (valid_a && match && (!hit || dsq_a < best)) begin
      best <= dsq_a;
    end
  end

  assign rt_sum = {1'b0, rt_root} + {1'b0, rt_bit};

  always_ff @(posedge clk) begin
    if (cmd.root_load) begin
      rt_n    <= {best, 16'h0000};
      rt_root <= '0;
      rt_bit  <= ROOT_BIT_TOP;
    end else if (cmd.root_step) begin
      if ({1'b0, rt_n} >= rt_sum) begin
        rt_n    <= rt_n - rt_sum[30:0];
        rt_root <= (rt_root >> 1) + rt_bit;
      end else begin
        rt_root <= rt_root >> 1;
      end
      rt_bit <= rt_bit >> 2;
    end
  end

  assign cap = {max_dist, 8'h00};

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.result_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.result_load) begin
      out_word.found       <= hit;
      out_word.distance_q8 <= (hit && rt_root < {16'd0, cap}) ? rt_root[14:0] : cap;
    end
  end

  assign sts.empty     = empty;
  assign sts.scan_last = (cx == x_hi) && (cy == y_hi);
  assign sts.root_done = rt_bit[0];
  assign sts.out_free  = !out_valid || out_ready;

  `WNLD_ASSERT(a_scan_in_window, cmd.scan_issue |-> (cx <= x_hi) && (cy <= y_hi), "scan left window")
  `WNLD_ASSERT(a_best_bound, hit |-> best <= BEST_MAX, "squared distance out of range")

endmodule

### design/wnld_ctrl.sv
`include "window_nearest_level_distance_macros.svh"

module wnld_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic                in_cmd,
  output wnld_pkg::ctrl_cmd_t cmd,
  input  wnld_pkg::dp_sts_t   sts
);

  wnld_pkg::state_t state, state_next;
  logic             accept;

  assign accept = in_valid && in_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= wnld_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      wnld_pkg::ST_IDLE: begin
        if (accept && in_cmd == wnld_pkg::CMD_QUERY) state_next = wnld_pkg::ST_CHECK;
      end
      wnld_pkg::ST_CHECK: begin
        state_next = sts.empty ? wnld_pkg::ST_ROOT_LOAD : wnld_pkg::ST_SCAN;
      end
      wnld_pkg::ST_SCAN: begin
        if (sts.scan_last) state_next = wnld_pkg::ST_DRAIN;
      end
      wnld_pkg::ST_DRAIN:     state_next = wnld_pkg::ST_ROOT_LOAD;
      wnld_pkg::ST_ROOT_LOAD: state_next = wnld_pkg::ST_ROOT;
      wnld_pkg::ST_ROOT: begin
        if (sts.root_done) state_next = wnld_pkg::ST_RESULT;
      end
      wnld_pkg::ST_RESULT: begin
        if (sts.out_free) state_next = wnld_pkg::ST_IDLE;
      end
      default: state_next = wnld_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    in_ready        = (state == wnld_pkg::ST_IDLE);
    cmd.start       = accept && in_cmd == wnld_pkg::CMD_QUERY;
    cmd.wr_en       = accept && in_cmd == wnld_pkg::CMD_WRITE;
    cmd.scan_issue  = (state == wnld_pkg::ST_SCAN);
    cmd.root_load   = (state == wnld_pkg::ST_ROOT_LOAD);
    cmd.root_step   = (state == wnld_pkg::ST_ROOT);
    cmd.result_load = (state == wnld_pkg::ST_RESULT) && sts.out_free;
  end

  `WNLD_ASSERT_ALWAYS(a_rst_idle, rst |=> state == wnld_pkg::ST_IDLE, "not idle after reset")
  `WNLD_ASSERT(a_scan_exit, state == wnld_pkg::ST_SCAN |=> state == wnld_pkg::ST_SCAN || state == wnld_pkg::ST_DRAIN, "scan left early")
  `WNLD_ASSERT(a_root_hold, state == wnld_pkg::ST_ROOT && !sts.root_done |=> state == wnld_pkg::ST_ROOT, "root cut short")

endmodule

### design/window_nearest_level_distance.sv
// Nearest matching height distance over a square window of a vertex height map.
// Input channel in_valid/in_ready carries one word: cmd, vert_x, vert_y, level.
// A write word (cmd 0) stores level at (vert_x, vert_y) and gives no result;
// write words can follow back to back.
// A query word (cmd 1) scans the window of radius max_dist, clipped to the grid, and
// returns one word on out_valid/out_ready: distance_q8 (unsigned Q7.8) and found.
// At the default radius 8 the clipped window holds at most 17x17 vertices, and an empty
// clipped window skips the scan. The scan reads one stored height per cycle from the
// height memory; the square root then finds one result bit per step.
// One query is in flight at a time; in_ready returns in the cycle after the result is
// loaded into the output register, even while that result waits.
// If the receiver stalls, the result holds in the output register and a following query
// waits at the end of its work until the register frees.
// Configuration words on cfg_valid/cfg_ready are always taken; write them only when idle.
// Reset restores the register defaults and idles the block; the height memory is not
// cleared, and reading a never-written vertex gives an undefined height.
module window_nearest_level_distance #(
  parameter int SIDE_VERTS = wnld_pkg::SIDE_VERTS_DEF
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             in_valid,
  output logic                             in_ready,
  input  wnld_pkg::in_word_t               in_word,
  output logic                             out_valid,
  input  logic                             out_ready,
  output wnld_pkg::out_word_t              out_word,
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [wnld_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [wnld_pkg::CFG_DATA_W-1:0]  cfg_data
);

  wnld_pkg::ctrl_cmd_t cmd;
  wnld_pkg::dp_sts_t   sts;

  assign cfg_ready = 1'b1;

  wnld_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_cmd   (in_word.cmd),
    .cmd      (cmd),
    .sts      (sts)
  );

  wnld_datapath #(
    .SIDE_VERTS (SIDE_VERTS)
  ) u_datapath (
    .clk       (clk),
    .rst       (rst),
    .in_word   (in_word),
    .cfg_valid (cfg_valid),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .out_ready (out_ready),
    .out_valid (out_valid),
    .out_word  (out_word),
    .cmd       (cmd),
    .sts       (sts)
  );

endmodule
